// ===== hdl/bchr_pkg.sv =====
// ----------------------------------------------------------------------------
// bchr_pkg
// Shared types, constants and helpers for the button combo hotkey recorder.
// ----------------------------------------------------------------------------
package bchr_pkg;

    localparam int NUM_BINDS = 14;
    localparam int TABLE_DEPTH = 16;
    localparam int BTN_W = 16;
    localparam int SLOT_W = 4;
    localparam int OP_W = 2;
    localparam int MAXB_W = 5;
    localparam int CNT_W = 5;
    localparam int HIT_W = 14;
    localparam int HIT_SLOTS = (NUM_BINDS < HIT_W) ? NUM_BINDS : HIT_W;
    localparam int CFG_IDX_W = 1;

    typedef logic [BTN_W-1:0] btn_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [HIT_W-1:0] hit_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_POLL   = 2'd0,
        OP_SET    = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_MASK = 1'd0,
        CFG_MAX_BUTTONS = 1'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_OFF     = 3'b001,
        PH_WAIT    = 3'b010,
        PH_CAPTURE = 3'b100
    } phase_t;

    localparam btn_t BUTTON_MASK_RST = 16'hFFFF;
    localparam logic [MAXB_W-1:0] MAX_BUTTONS_RST = 5'd3;

    localparam btn_t DEFAULT_COMBOS [TABLE_DEPTH] = '{
        16'h0408, 16'h0808, 16'h0801, 16'h0802, 16'h0804, 16'h0201, 16'h0202, 16'h1800,
        16'h0001, 16'h0002, 16'h0010, 16'h0218, 16'h0A08, 16'h0208, 16'h0000, 16'h0000
    };

    function automatic cnt_t bit_count(input btn_t v);
        cnt_t n;
        n = '0;
        for (int i = 0; i < BTN_W; i++)
        begin
            n = n + cnt_t'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== hdl/bchr_if.sv =====
// ----------------------------------------------------------------------------
// bchr_req_if / bchr_rsp_if
// Valid/ready channels for operations in and hit reports out.
// ----------------------------------------------------------------------------
interface bchr_req_if
    import bchr_pkg::*;
    ();
    logic   valid;
    logic   ready;
    op_t    operation;
    btn_t   buttons;
    slot_t  bind_index;
    btn_t   new_mask;

    modport source (output valid, output operation, output buttons,
                    output bind_index, output new_mask, input ready);
    modport sink   (input valid, input operation, input buttons,
                    input bind_index, input new_mask, output ready);
endinterface

interface bchr_rsp_if
    import bchr_pkg::*;
    ();
    logic   valid;
    logic   ready;
    hit_t   held_hits;
    hit_t   pressed_hits;
    logic   recording;
    logic   table_dirty;

    modport source (output valid, output held_hits, output pressed_hits,
                    output recording, output table_dirty, input ready);
    modport sink   (input valid, input held_hits, input pressed_hits,
                    input recording, input table_dirty, output ready);
endinterface

// ===== hdl/button_combo_hotkey_recorder.sv =====
// ----------------------------------------------------------------------------
// button_combo_hotkey_recorder
// Combo table with exact-match hotkey detection and a learn mode.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake     Carries
//  req       in    valid/ready   operation, buttons, bind_index, new_mask
//  rsp       out   valid/ready   held_hits, pressed_hits, recording, table_dirty
//  cfg       in    cfg_we        cfg_index, cfg_data (button_mask, max_buttons)
//
//  One item per cycle while rsp is not stalled. A req transfer fills the input
//  register; each operation updates the state from it, writing the result
//  register, which drives rsp, on the same edge.
//  Reset loads the default combos and clears all recorder state.
//  A stalled rsp holds the input register; req stays ready while it is empty.
// ----------------------------------------------------------------------------
module button_combo_hotkey_recorder
    import bchr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bchr_req_if.sink             req,
    bchr_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  btn_t                 cfg_data
);

    btn_t                button_mask_reg;
    logic [MAXB_W-1:0]   max_buttons_reg;

    logic   in_valid_reg;
    op_t    op_reg;
    btn_t   buttons_reg;
    slot_t  bind_index_reg;
    btn_t   new_mask_reg;

    btn_t   table_reg [NUM_BINDS];
    btn_t   table_next [NUM_BINDS];
    btn_t   held_now_reg, held_now_next;
    btn_t   held_before_reg, held_before_next;
    btn_t   accum_reg, accum_next;
    phase_t phase_reg, phase_next;
    slot_t  slot_reg, slot_next;
    logic   silent_reg, silent_next;
    logic   dirty_reg, dirty_next;

    logic   out_valid_reg;
    hit_t   held_hits_reg, held_hits_next;
    hit_t   pressed_hits_reg, pressed_hits_next;
    logic   recording_reg;
    logic   dirty_out_reg;

    logic   advance;
    logic   commit;
    btn_t   commit_val;
    logic   wr_req;
    slot_t  wr_slot;
    btn_t   wr_val;
    logic   wr_en;
    btn_t   latched;
    logic   live;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_mask_reg <= BUTTON_MASK_RST;
            max_buttons_reg <= MAX_BUTTONS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BUTTON_MASK: button_mask_reg <= cfg_data;
                CFG_MAX_BUTTONS: max_buttons_reg <= cfg_data[MAXB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg         <= req.operation;
            buttons_reg    <= req.buttons;
            bind_index_reg <= req.bind_index;
            new_mask_reg   <= req.new_mask;
        end
    end

    // operation decode and state update
    always_comb
    begin
        latched          = buttons_reg & button_mask_reg;
        held_now_next    = held_now_reg;
        held_before_next = held_before_reg;
        accum_next       = accum_reg;
        phase_next       = phase_reg;
        slot_next        = slot_reg;
        silent_next      = silent_reg;
        commit           = 1'b0;
        commit_val       = accum_reg;
        wr_req           = 1'b0;
        wr_slot          = bind_index_reg;
        wr_val           = new_mask_reg;

        case (op_reg)
            OP_POLL:
            begin
                held_before_next = held_now_reg;
                held_now_next    = latched;
                if (silent_reg && phase_reg == PH_OFF && latched == '0)
                    silent_next = 1'b0;
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (latched == '0)
                            phase_next = PH_CAPTURE;
                    end
                    PH_CAPTURE:
                    begin
                        if ((accum_reg & ~latched) != '0)
                        begin
                            commit = 1'b1;
                        end
                        else
                        begin
                            accum_next = latched;
                            commit_val = latched;
                            if (bit_count(latched) >= cnt_t'(max_buttons_reg))
                                commit = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (commit)
                begin
                    phase_next = PH_OFF;
                    accum_next = '0;
                    wr_req     = (commit_val != '0);
                    wr_slot    = slot_reg;
                    wr_val     = commit_val;
                end
            end
            OP_SET:
            begin
                wr_req = 1'b1;
            end
            OP_BEGIN:
            begin
                slot_next   = bind_index_reg;
                accum_next  = '0;
                phase_next  = PH_WAIT;
                silent_next = 1'b1;
            end
            OP_CANCEL:
            begin
                phase_next = PH_OFF;
                accum_next = '0;
            end
            default: ;
        endcase
    end

    // single table write port with the limit and range checks
    always_comb
    begin
        btn_t wm;
        wm    = wr_val & button_mask_reg;
        wr_en = wr_req
             && (bit_count(wm) <= cnt_t'(max_buttons_reg))
             && ({1'b0, wr_slot} < (SLOT_W+1)'(NUM_BINDS));
        dirty_next = dirty_reg;
        for (int i = 0; i < NUM_BINDS; i++)
        begin
            table_next[i] = table_reg[i];
            if (wr_en && wr_slot == SLOT_W'(i))
            begin
                table_next[i] = wm;
                if (table_reg[i] != wm)
                    dirty_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        live              = (phase_next == PH_OFF) && !silent_next;
        held_hits_next    = '0;
        pressed_hits_next = '0;
        for (int i = 0; i < HIT_SLOTS; i++)
        begin
            if (live && table_next[i] != '0 && held_now_next == table_next[i])
            begin
                held_hits_next[i] = 1'b1;
                if (held_before_next != table_next[i])
                    pressed_hits_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINDS; i++)
                table_reg[i] <= DEFAULT_COMBOS[i];
            held_now_reg    <= '0;
            held_before_reg <= '0;
            accum_reg       <= '0;
            phase_reg       <= PH_OFF;
            slot_reg        <= '0;
            silent_reg      <= 1'b0;
            dirty_reg       <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_BINDS; i++)
                table_reg[i] <= table_next[i];
            held_now_reg    <= held_now_next;
            held_before_reg <= held_before_next;
            accum_reg       <= accum_next;
            phase_reg       <= phase_next;
            slot_reg        <= slot_next;
            silent_reg      <= silent_next;
            dirty_reg       <= dirty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held_hits_reg    <= held_hits_next;
            pressed_hits_reg <= pressed_hits_next;
            recording_reg    <= (phase_next != PH_OFF);
            dirty_out_reg    <= dirty_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.held_hits    = held_hits_reg;
    assign rsp.pressed_hits = pressed_hits_reg;
    assign rsp.recording    = recording_reg;
    assign rsp.table_dirty  = dirty_out_reg;

    a_no_hits_while_recording: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.recording && rsp.held_hits != '0))
        else $error("hotkey hit reported while recording");

    a_pressed_within_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.pressed_hits & ~rsp.held_hits) == '0))
        else $error("pressed hit without held hit");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg |=> dirty_reg)
        else $error("dirty flag cleared");

    a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending operation lost under stall");

endmodule

// ===== tb/hit_monitor.sv =====
// ----------------------------------------------------------------------------
// hit_monitor
// Watches the operation and hit report channels and the register port of the
// hotkey recorder. Keeps its own copy of the combo table and the learn state,
// works out the report each accepted operation should produce and compares it
// field by field with the reports that come back.
// ----------------------------------------------------------------------------
module hit_monitor
    import bchr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bchr_req_if                  req,
    bchr_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  btn_t                 cfg_data,
    output int                   fail_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        hit_t held;
        hit_t pressed;
        logic recording;
        logic dirty;
    } report_t;

    btn_t               combos [TABLE_DEPTH];
    btn_t               pad_now;
    btn_t               pad_prev;
    btn_t               learn_accum;
    phase_t             learn_phase;
    slot_t              learn_slot;
    logic               learn_silent;
    logic               table_changed;
    btn_t               pad_filter;
    logic [MAXB_W-1:0]  combo_limit;
    report_t            reports_due [$];
    int                 mismatches;

    function automatic void clear_state();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            combos[i] = DEFAULT_COMBOS[i];
        end
        pad_now       = '0;
        pad_prev      = '0;
        learn_accum   = '0;
        learn_phase   = PH_OFF;
        learn_slot    = '0;
        learn_silent  = 1'b0;
        table_changed = 1'b0;
        pad_filter    = 16'hFFFF;
        combo_limit   = 5'd3;
    endfunction

    function automatic void store_combo(slot_t idx, btn_t mask);
        btn_t m;
        m = mask & pad_filter;
        if ($countones(m) > int'(combo_limit))
            return;
        if (int'(idx) >= NUM_BINDS)
            return;
        if (combos[idx] != m)
            table_changed = 1'b1;
        combos[idx] = m;
    endfunction

    function automatic void finish_learning();
        if (learn_accum != '0)
            store_combo(learn_slot, learn_accum);
        learn_phase = PH_OFF;
        learn_accum = '0;
    endfunction

    function automatic void take_poll(btn_t pad);
        pad_prev = pad_now;
        pad_now  = pad & pad_filter;
        if (learn_silent && learn_phase == PH_OFF && pad_now == '0)
            learn_silent = 1'b0;
        if (learn_phase == PH_WAIT)
        begin
            if (pad_now == '0)
                learn_phase = PH_CAPTURE;
        end
        else if (learn_phase == PH_CAPTURE)
        begin
            // any button let go commits what was gathered
            if ((learn_accum & ~pad_now) != '0)
            begin
                finish_learning();
            end
            else
            begin
                learn_accum = pad_now;
                if ($countones(learn_accum) >= int'(combo_limit))
                    finish_learning();
            end
        end
    endfunction

    function automatic report_t predict_report(op_t op, btn_t pad, slot_t idx, btn_t mask);
        report_t r;
        logic    live;
        case (op)
            OP_POLL:
                take_poll(pad);
            OP_SET:
                store_combo(idx, mask);
            OP_BEGIN:
            begin
                learn_slot   = idx;
                learn_accum  = '0;
                learn_phase  = PH_WAIT;
                learn_silent = 1'b1;
            end
            default:
            begin
                learn_phase = PH_OFF;
                learn_accum = '0;
            end
        endcase
        live = (learn_phase == PH_OFF) && !learn_silent;
        r = '0;
        for (int i = 0; i < NUM_BINDS && i < HIT_W; i++)
        begin
            if (combos[i] != '0 && live && pad_now == combos[i])
            begin
                r.held[i] = 1'b1;
                if (pad_prev != combos[i])
                    r.pressed[i] = 1'b1;
            end
        end
        r.recording = (learn_phase != PH_OFF);
        r.dirty     = table_changed;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        report_t due;
        if (!rst_n)
        begin
            clear_state();
            reports_due.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BUTTON_MASK)
                    pad_filter = cfg_data;
                else if (cfg_index == CFG_MAX_BUTTONS)
                    combo_limit = cfg_data[MAXB_W-1:0];
            end
            if (rsp.valid && rsp.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: report transfer with none outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    due = reports_due.pop_front();
                    if (rsp.held_hits !== due.held)
                    begin
                        $display("%0t: held_hits expected %h, got %h",
                                 $time, due.held, rsp.held_hits);
                        mismatches++;
                    end
                    if (rsp.pressed_hits !== due.pressed)
                    begin
                        $display("%0t: pressed_hits expected %h, got %h",
                                 $time, due.pressed, rsp.pressed_hits);
                        mismatches++;
                    end
                    if (rsp.recording !== due.recording)
                    begin
                        $display("%0t: recording expected %b, got %b",
                                 $time, due.recording, rsp.recording);
                        mismatches++;
                    end
                    if (rsp.table_dirty !== due.dirty)
                    begin
                        $display("%0t: table_dirty expected %b, got %b",
                                 $time, due.dirty, rsp.table_dirty);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                reports_due.push_back(predict_report(req.operation, req.buttons,
                                                     req.bind_index, req.new_mask));
            fail_count  <= mismatches;
            outstanding <= reports_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the hotkey recorder: a directed pass over the table defaults, the
// set checks and a full learn cycle, then random polls, sets and learn runs
// under a range of button masks and combo limits. Both channels idle at
// random. hit_monitor does the checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
    import bchr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 75;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    btn_t                 cfg_data;
    int                   fail_count;
    int                   outstanding;
    int                   cycles = 0;
    int                   items_sent = 0;
    int                   sink_hold = 0;
    logic                 steady = 1'b0;

    bchr_req_if req ();
    bchr_rsp_if rsp ();

    button_combo_hotkey_recorder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hit_monitor hits (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("button_combo_hotkey_recorder test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            rsp.ready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            rsp.ready <= 1'b1;
            sink_hold = pick_gap();
        end
    end

    function automatic btn_t pick_pad();
        int   r;
        btn_t p;
        r = $urandom_range(0, 99);
        if (r < 35)
            return DEFAULT_COMBOS[$urandom_range(0, NUM_BINDS - 1)];
        if (r < 50)
            return '0;
        if (r < 75)
        begin
            p = '0;
            repeat ($urandom_range(1, 3))
                p |= btn_t'(1) << $urandom_range(0, BTN_W - 1);
            return p;
        end
        return btn_t'($urandom);
    endfunction

    task automatic issue(op_t op, btn_t pad, slot_t idx, btn_t mask);
        int gap;
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.buttons    <= pad;
        req.bind_index <= idx;
        req.new_mask   <= mask;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic poll(btn_t pad);
        issue(OP_POLL, pad, slot_t'($urandom), btn_t'($urandom));
    endtask

    // hold off until every report has come back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(btn_t mask, logic [MAXB_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BUTTON_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= CFG_MAX_BUTTONS;
        cfg_data  <= btn_t'(limit);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic learn_run();
        btn_t held;
        issue(OP_BEGIN, btn_t'($urandom), slot_t'($urandom_range(0, 15)), btn_t'($urandom));
        repeat ($urandom_range(0, 2))
            poll(pick_pad());
        poll('0);
        held = '0;
        repeat ($urandom_range(1, 5))
        begin
            held |= btn_t'(1) << $urandom_range(0, BTN_W - 1);
            poll(held);
        end
        case ($urandom_range(0, 3))
            0: poll(held & ~(btn_t'(1) << $urandom_range(0, BTN_W - 1)));
            1: poll('0);
            2: issue(OP_CANCEL, btn_t'($urandom), slot_t'($urandom), btn_t'($urandom));
            default: ;
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            poll('0);
            poll(held);
        end
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            poll(pick_pad());
        else if (r < 50)
            issue(OP_SET, btn_t'($urandom), slot_t'($urandom_range(0, 15)), pick_pad());
        else if (r < 75)
            learn_run();
        else if (r < 88)
        begin
            poll('0);
            poll(DEFAULT_COMBOS[$urandom_range(0, NUM_BINDS - 1)]);
        end
        else if (r < 94)
            issue(OP_CANCEL, btn_t'($urandom), slot_t'($urandom), btn_t'($urandom));
        else
            issue(OP_BEGIN, btn_t'($urandom), slot_t'($urandom), btn_t'($urandom));
    endtask

    initial
    begin
        btn_t              masks  [7];
        logic [MAXB_W-1:0] limits [7];
        int                phase_end;
        logic              paused;

        masks  = '{16'hFFFF, 16'h0F1F, 16'hF0F0, 16'hFFFF, 16'h0000,
                   btn_t'($urandom), 16'hFFFF};
        limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd16,
                   5'($urandom_range(0, 31)), 5'd3};

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BUTTON_MASK;
        cfg_data       = '0;
        req.valid      = 1'b0;
        req.operation  = OP_POLL;
        req.buttons    = '0;
        req.bind_index = '0;
        req.new_mask   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: match, held, no match
        poll(16'h0000);
        poll(16'h0408);
        poll(16'h0408);
        poll(16'hFFFF);
        // sets: past NUM_BINDS, at NUM_BINDS, too many buttons, unchanged, emptied
        issue(OP_SET, '0, 4'd15, 16'h0001);
        issue(OP_SET, '0, 4'd14, 16'h0001);
        issue(OP_SET, '0, 4'd2, 16'hF000);
        issue(OP_SET, '0, 4'd1, 16'h0808);
        issue(OP_SET, '0, 4'd3, 16'h0000);
        poll(16'h0802);
        // learn into slot 5, committed by a release
        issue(OP_BEGIN, '0, 4'd5, '0);
        poll(16'h0001);
        poll(16'h0000);
        poll(16'h0100);
        poll(16'h0300);
        poll(16'h0100);
        poll(16'h0000);
        poll(16'h0300);
        // learn into a slot past the table, committed at the button limit
        issue(OP_BEGIN, '0, 4'd15, '0);
        poll(16'h0000);
        poll(16'h0007);
        issue(OP_BEGIN, '0, 4'd4, '0);
        issue(OP_CANCEL, '0, '0, '0);
        poll(16'h0000);
        issue(OP_CANCEL, 16'hFFFF, 4'hF, 16'hFFFF);

        for (int p = 0; p < 7; p++)
        begin
            drain();
            write_regs(masks[p], limits[p]);
            steady    = (p == 2);
            phase_end = items_sent + PHASE_ITEMS;
            paused    = 1'b0;
            while (items_sent < phase_end)
            begin
                if (!paused && items_sent >= phase_end - PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                random_item();
            end
        end
        steady = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("button_combo_hotkey_recorder test passed");
        else
            $display("button_combo_hotkey_recorder test failed");
        $finish;
    end

endmodule

// ===== button_combo_hotkey_recorder.f =====
hdl/bchr_pkg.sv
hdl/bchr_if.sv
hdl/button_combo_hotkey_recorder.sv
tb/hit_monitor.sv
tb/testbench.sv
